FILE: rtl/rtor_pkg.sv
// Package with the types, constants, microcode table and helper functions of the rasterizer.
`timescale 1ns / 1ps

package rtor_pkg;

  localparam int GRID_SIZE_DEF = 16;

  localparam int CW = 4;
  localparam int DW = CW + 1;
  localparam int SQW = 2 * CW;

  localparam logic [1:0] GLYPH_PLUS = 2'd0;
  localparam logic [1:0] GLYPH_DASH = 2'd1;
  localparam logic [1:0] GLYPH_BAR = 2'd2;

  localparam logic [SQW-1:0] SQ_TABLE [16] = '{
    8'd0, 8'd1, 8'd4, 8'd9, 8'd16, 8'd25, 8'd36, 8'd49,
    8'd64, 8'd81, 8'd100, 8'd121, 8'd144, 8'd169, 8'd196, 8'd225
  };

  typedef enum logic [2:0] {
    UPC_IDLE,
    UPC_INIT,
    UPC_LINE,
    UPC_HORZ,
    UPC_VERT
  } upc_e;

  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_SETUP,
    ACT_LINE,
    ACT_HORZ,
    ACT_VERT
  } act_e;

  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_ALWAYS,
    COND_LINE_DONE,
    COND_H_DONE,
    COND_V_DONE
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_e  jump;
  } ucode_t;

  // Each step stays put until its condition holds and then jumps.
  function automatic ucode_t ucode_rom(upc_e pc);
    ucode_t w;
    case (pc)
      UPC_IDLE: w = '{act: ACT_LOAD,  cond: COND_ACCEPT,    jump: UPC_INIT};
      UPC_INIT: w = '{act: ACT_SETUP, cond: COND_ALWAYS,    jump: UPC_LINE};
      UPC_LINE: w = '{act: ACT_LINE,  cond: COND_LINE_DONE, jump: UPC_HORZ};
      UPC_HORZ: w = '{act: ACT_HORZ,  cond: COND_H_DONE,    jump: UPC_VERT};
      UPC_VERT: w = '{act: ACT_VERT,  cond: COND_V_DONE,    jump: UPC_IDLE};
      default:  w = '{act: ACT_LOAD,  cond: COND_ALWAYS,    jump: UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [CW-1:0] abs_of(logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return m[CW-1:0];
  endfunction

  function automatic logic [SQW-1:0] sq_of(logic signed [DW-1:0] d);
    return SQ_TABLE[abs_of(d)];
  endfunction

  function automatic logic far_of(logic signed [DW-1:0] dx, logic signed [DW-1:0] dy);
    logic [SQW:0] s;
    s = {1'b0, sq_of(dx)} + {1'b0, sq_of(dy)};
    return s > (SQW + 1)'(4);
  endfunction

  // Step of one axis: sign of d when 3*d*d exceeds the square of the other axis.
  function automatic logic signed [1:0] step_of(logic signed [DW-1:0] d,
                                                logic signed [DW-1:0] o);
    logic [SQW+1:0] three;
    logic signed [1:0] s;
    three = {2'b00, sq_of(d)} + {1'b0, sq_of(d), 1'b0};
    if (three > {2'b00, sq_of(o)}) begin
      s = d[DW-1] ? -2'sd1 : ((d != '0) ? 2'sd1 : 2'sd0);
    end else begin
      s = 2'sd0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/rtor_in_if.sv
// Handshake channel that carries one source and destination cell pair.
`timescale 1ns / 1ps

interface rtor_in_if;
  logic                    valid;
  logic                    ready;
  logic [rtor_pkg::CW-1:0] src_x;
  logic [rtor_pkg::CW-1:0] src_y;
  logic [rtor_pkg::CW-1:0] dst_x;
  logic [rtor_pkg::CW-1:0] dst_y;

  modport source (output valid, output src_x, output src_y, output dst_x, output dst_y,
                  input ready);
  modport sink (input valid, input src_x, input src_y, input dst_x, input dst_y,
                output ready);
endinterface

FILE: rtl/rtor_out_if.sv
// Handshake channel that carries one pixel write.
`timescale 1ns / 1ps

interface rtor_out_if;
  logic                    valid;
  logic                    ready;
  logic [rtor_pkg::CW-1:0] pix_x;
  logic [rtor_pkg::CW-1:0] pix_y;
  logic [1:0]              glyph;
  logic                    last;

  modport source (output valid, output pix_x, output pix_y, output glyph, output last,
                  input ready);
  modport sink (input valid, input pix_x, input pix_y, input glyph, input last,
                output ready);
endinterface

FILE: rtl/right_triangle_outline_raster_top.sv
// Top level of the right triangle outline rasterizer with its microcoded sequencer.
`timescale 1ns / 1ps

// Each accepted cell pair produces the outline pixel writes of a right triangle: first the
// diagonal line toward the destination, then the horizontal leg on the source row, then the
// vertical leg on the destination column, with last set on the final write. A small control
// table steps a plain datapath, one pixel write per cycle while the output side keeps up.
// A pair keeps ready low after its transfer until the sequencer is back in idle, so the
// next pair is not taken before all writes of this one: the table runs one setup step, one
// step per pixel write and one step to leave each of the three phases. A finished write
// that waits for the output side holds the sequencer in its step. Coordinates at or above
// GRID_SIZE are saturated to GRID_SIZE - 1.
module right_triangle_outline_raster_top #(
  parameter int GRID_SIZE = rtor_pkg::GRID_SIZE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rtor_in_if.sink        in_i,
  rtor_out_if.source     out_o
);

  localparam int CW = rtor_pkg::CW;
  localparam int DW = rtor_pkg::DW;
  localparam int MAX_C = (GRID_SIZE < 16) ? GRID_SIZE - 1 : 15;
  localparam logic [CW-1:0] MaxCoord = CW'(MAX_C);

  function automatic logic [CW-1:0] clamp(logic [CW-1:0] v);
    return (v > MaxCoord) ? MaxCoord : v;
  endfunction

  rtor_pkg::upc_e   pc_q, pc_d;
  rtor_pkg::ucode_t uw;

  logic [CW-1:0] sx_q, sy_q, tx_q, ty_q;
  logic [CW-1:0] cx_q, cy_q, hx_q, vy_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic          far_q;
  logic [CW-1:0] hcnt_q, vcnt_q;

  logic          out_valid_q;
  logic [CW-1:0] out_x_q, out_y_q;
  logic [1:0]    out_glyph_q;
  logic          out_last_q;

  logic          cond;
  logic          out_free;
  logic          do_emit;
  logic          ld;

  logic signed [1:0]    mx, my;
  logic [CW-1:0]        ncx, ncy;
  logic signed [DW-1:0] ndx, ndy;
  logic                 nfar;
  logic signed [DW-1:0] idx, idy;
  logic                 hpos, vpos;

  logic [CW-1:0] emit_x, emit_y;
  logic [1:0]    emit_glyph;
  logic          emit_last;

  assign uw       = rtor_pkg::ucode_rom(pc_q);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    case (uw.cond)
      rtor_pkg::COND_ACCEPT:    cond = in_i.valid;
      rtor_pkg::COND_ALWAYS:    cond = 1'b1;
      rtor_pkg::COND_LINE_DONE: cond = !far_q;
      rtor_pkg::COND_H_DONE:    cond = (hcnt_q == '0);
      rtor_pkg::COND_V_DONE:    cond = (vcnt_q == '0);
      default:                  cond = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = cond ? uw.jump : pc_q;
  end

  assign mx   = rtor_pkg::step_of(dx_q, dy_q);
  assign my   = rtor_pkg::step_of(dy_q, dx_q);
  assign ncx  = cx_q + {{(CW-2){mx[1]}}, mx};
  assign ncy  = cy_q + {{(CW-2){my[1]}}, my};
  assign ndx  = dx_q - {{(DW-2){mx[1]}}, mx};
  assign ndy  = dy_q - {{(DW-2){my[1]}}, my};
  assign nfar = rtor_pkg::far_of(ndx, ndy);

  assign idx  = $signed({1'b0, tx_q}) - $signed({1'b0, sx_q});
  assign idy  = $signed({1'b0, ty_q}) - $signed({1'b0, sy_q});
  assign hpos = !idx[DW-1];
  assign vpos = !idy[DW-1];

  always_comb begin
    ld         = 1'b0;
    do_emit    = 1'b0;
    emit_x     = ncx;
    emit_y     = ncy;
    emit_glyph = rtor_pkg::GLYPH_PLUS;
    emit_last  = 1'b0;
    case (uw.act)
      rtor_pkg::ACT_LOAD: begin
        ld = 1'b1;
      end
      rtor_pkg::ACT_SETUP: begin
        ld = 1'b0;
      end
      rtor_pkg::ACT_LINE: begin
        do_emit   = !cond && out_free;
        emit_last = !nfar && (hcnt_q == '0) && (vcnt_q == '0);
      end
      rtor_pkg::ACT_HORZ: begin
        do_emit    = !cond && out_free;
        emit_x     = hx_q;
        emit_y     = sy_q;
        emit_glyph = rtor_pkg::GLYPH_DASH;
        emit_last  = (hcnt_q == CW'(1)) && (vcnt_q == '0);
      end
      rtor_pkg::ACT_VERT: begin
        do_emit    = !cond && out_free;
        emit_x     = tx_q;
        emit_y     = vy_q;
        emit_glyph = rtor_pkg::GLYPH_BAR;
        emit_last  = (vcnt_q == CW'(1));
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  assign in_i.ready = ld && rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rtor_pkg::UPC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && in_i.valid) begin
      sx_q <= clamp(in_i.src_x);
      sy_q <= clamp(in_i.src_y);
      tx_q <= clamp(in_i.dst_x);
      ty_q <= clamp(in_i.dst_y);
    end
    if (uw.act == rtor_pkg::ACT_SETUP) begin
      cx_q   <= sx_q;
      cy_q   <= sy_q;
      dx_q   <= idx;
      dy_q   <= idy;
      far_q  <= rtor_pkg::far_of(idx, idy);
      hcnt_q <= (idx != '0) ? rtor_pkg::abs_of(idx) - CW'(1) : '0;
      vcnt_q <= (idy != '0) ? rtor_pkg::abs_of(idy) - CW'(1) : '0;
      hx_q   <= hpos ? sx_q + CW'(1) : sx_q - CW'(1);
      vy_q   <= vpos ? sy_q + CW'(1) : sy_q - CW'(1);
    end
    if (do_emit) begin
      out_x_q     <= emit_x;
      out_y_q     <= emit_y;
      out_glyph_q <= emit_glyph;
      out_last_q  <= emit_last;
      case (uw.act)
        rtor_pkg::ACT_LINE: begin
          cx_q  <= ncx;
          cy_q  <= ncy;
          dx_q  <= ndx;
          dy_q  <= ndy;
          far_q <= nfar;
        end
        rtor_pkg::ACT_HORZ: begin
          hcnt_q <= hcnt_q - CW'(1);
          hx_q   <= hpos ? hx_q + CW'(1) : hx_q - CW'(1);
        end
        rtor_pkg::ACT_VERT: begin
          vcnt_q <= vcnt_q - CW'(1);
          vy_q   <= vpos ? vy_q + CW'(1) : vy_q - CW'(1);
        end
        default: begin
          far_q <= far_q;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.pix_x = out_x_q;
  assign out_o.pix_y = out_y_q;
  assign out_o.glyph = out_glyph_q;
  assign out_o.last  = out_last_q;

endmodule
